### sv/cmsf_pkg.sv
// Package for the calibrated median sensor filter.
// Holds the field widths, register indexes and reset values, the config struct
// and the back-end state type. No dependencies.
package cmsf_pkg;

  localparam int CODE_W      = 10;   // converter code width
  localparam int DATA_W      = 32;   // Q16.16 value width
  localparam int S_TDATA_W   = 16;   // raw_code padded to whole bytes
  localparam int M_TDATA_W   = 32;   // median_value
  localparam int CFG_INDEX_W = 3;
  localparam int PROD_W      = CODE_W + 1 + DATA_W;  // signed code * gain
  localparam int SUM_W       = PROD_W + 1;           // product + offset

  localparam int WINDOW_DEF      = 5;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Register indexes on the config port
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_THRESH = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_MODE = 3'd4;

  // Reset values (Q16.16)
  localparam logic signed [DATA_W-1:0] GAIN_RST       = 32'sd320;
  localparam logic signed [DATA_W-1:0] OFFSET_RST     = 32'sd0;
  localparam logic signed [DATA_W-1:0] LOW_THRESH_RST = 32'sd6554;
  localparam logic signed [DATA_W-1:0] HIGH_LIMIT_RST = 32'sd917504;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] gain;
    logic signed [DATA_W-1:0] offset;
    logic signed [DATA_W-1:0] low_threshold;
    logic signed [DATA_W-1:0] high_limit;
    logic                     range_mode;
  } cfg_t;

  typedef enum logic [1:0] {
    S_FILL,   // collecting calibrated values into the window
    S_SORT,   // odd-even transposition passes over the window
    S_DONE    // window sorted, waiting for the output register
  } back_state_t;

endpackage

### sv/cmsf_front.sv
// Front end: accepts raw converter codes and calibrates them.
// Two stages: multiply by gain, then add offset, saturate and threshold.
// Depends on cmsf_pkg.
module cmsf_front import cmsf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CODE_W-1:0]        raw_code,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_data
);

  logic                     v1;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_next;
  logic                     v2;
  logic signed [DATA_W-1:0] cal;
  logic signed [DATA_W-1:0] cal_next;
  logic signed [SUM_W-1:0]  sum;
  logic signed [DATA_W-1:0] sat;
  logic                     adv1;
  logic                     adv2;

  assign adv2     = !v2 || out_ready;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  assign prod_next = $signed({1'b0, raw_code}) * cfg.gain;

  always_comb begin
    sum = SUM_W'(prod) + SUM_W'(cfg.offset);
    if (sum > SUM_W'(SAT_MAX)) begin
      sat = SAT_MAX;
    end else if (sum < SUM_W'(SAT_MIN)) begin
      sat = SAT_MIN;
    end else begin
      sat = sum[DATA_W-1:0];
    end
    cal_next = sat;
    if (sat < cfg.low_threshold) begin
      cal_next = '0;
    end
    if (cfg.range_mode && (sat > cfg.high_limit)) begin
      cal_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      prod <= prod_next;
    end
    if (adv2 && v1) begin
      cal <= cal_next;
    end
  end

  assign out_valid = v2;
  assign out_data  = cal;

endmodule

### sv/cmsf_queue.sv
// Small register FIFO between the calibration front end and the median back end.
// Depends on cmsf_pkg.
module cmsf_queue import cmsf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF   // 2 or more
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]         wr_ptr;
  logic [PTR_W-1:0]         rd_ptr;
  logic [CNT_W-1:0]         count;
  logic                     wr;
  logic                     rd;

  assign in_ready  = (count != CNT_FULL);
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign wr        = in_valid && in_ready;
  assign rd        = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= in_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue count beyond depth");

endmodule

### sv/cmsf_back.sv
// Back end: collects calibrated values into a window, sorts it with
// odd-even transposition passes and loads the median into the output register.
// Depends on cmsf_pkg.
module cmsf_back import cmsf_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF   // 1..16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_data,
  output logic                     m_valid,
  input  logic                     m_ready,
  output logic signed [DATA_W-1:0] m_data
);

  localparam int CNT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW - 1);

  back_state_t state;
  back_state_t state_next;

  logic signed [DATA_W-1:0] win    [WINDOW];
  logic signed [DATA_W-1:0] sorted [WINDOW];
  logic signed [DATA_W-1:0] med;
  logic [CNT_W-1:0]         cnt;
  logic                     take;
  logic                     sort_en;
  logic                     load_out;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_FILL: begin
        if (in_valid && (cnt == CNT_LAST)) begin
          state_next = S_SORT;
        end
      end
      S_SORT: begin
        if (cnt == CNT_LAST) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!m_valid || m_ready) begin
          state_next = S_FILL;
        end
      end
      default: state_next = S_FILL;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    sort_en  = 1'b0;
    load_out = 1'b0;
    case (state)
      S_FILL:  in_ready = 1'b1;
      S_SORT:  sort_en  = 1'b1;
      S_DONE:  load_out = !m_valid || m_ready;
      default: in_ready = 1'b0;
    endcase
  end

  assign take = in_valid && in_ready;

  // one transposition pass; pair parity alternates with the pass count
  always_comb begin
    for (int k = 0; k < WINDOW; k++) begin
      sorted[k] = win[k];
    end
    for (int k = 0; k < WINDOW - 1; k++) begin
      if (((k % 2) == int'(cnt[0])) && (win[k] > win[k+1])) begin
        sorted[k]   = win[k+1];
        sorted[k+1] = win[k];
      end
    end
  end

  generate
    if (WINDOW % 2 == 1) begin : g_odd
      assign med = win[WINDOW/2];
    end else begin : g_even
      logic signed [DATA_W:0] msum;
      // floored average: arithmetic shift of the 33-bit sum
      assign msum = (DATA_W+1)'(win[WINDOW/2-1]) + (DATA_W+1)'(win[WINDOW/2]);
      assign med  = msum[DATA_W:1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_FILL;
      cnt     <= '0;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (take || sort_en) begin
        cnt <= (cnt == CNT_LAST) ? '0 : cnt + 1'b1;
      end
      if (load_out) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      win[0] <= in_data;
      for (int k = 1; k < WINDOW; k++) begin
        win[k] <= win[k-1];
      end
    end else if (sort_en) begin
      for (int k = 0; k < WINDOW; k++) begin
        win[k] <= sorted[k];
      end
    end
    if (load_out) begin
      m_data <= med;
    end
  end

  a_fill_to_sort: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL && in_valid && cnt == CNT_LAST) |=> (state == S_SORT && cnt == '0))
    else $error("full window did not start sorting");

  a_sort_to_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_SORT && cnt == CNT_LAST) |=> (state == S_DONE && cnt == '0))
    else $error("sort did not finish after WINDOW passes");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside of the done state");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && m_valid && !m_ready) |=> state == S_DONE)
    else $error("left done state while output was blocked");

endmodule

### sv/calibrated_median_sensor_filter.sv
// Top level of the calibrated median sensor filter.
// Holds the config registers and ties front end, queue and back end together.
// Depends on cmsf_pkg, cmsf_front, cmsf_queue, cmsf_back.
//
// Usage:
//   s_* channel: one 10-bit converter code per item. Each code is calibrated
//   as code * gain + offset (Q16.16), saturated to 32 bits and zeroed by the
//   threshold rule (floor mode: below low_threshold; range mode: outside
//   low_threshold..high_limit).
//   m_* channel: one Q16.16 median per WINDOW input items; an even window
//   gives the floored average of the two middle values.
//   cfg_*: write-only registers, written when cfg_we is high; write only
//   while the block is idle. Indexes above range_mode are ignored.
// Timing:
//   The front end is a 2-stage pipeline (multiply, then add/saturate/compare)
//   feeding a QUEUE_DEPTH-entry FIFO. The back end shifts in one value per
//   cycle while the FIFO holds data, then runs WINDOW odd-even sort passes
//   and loads the median into the output register once that is free. It
//   takes no new items while sorting or holding a result; the FIFO absorbs
//   input that arrives during a sort.
// Reset (rst, synchronous) restores register defaults, empties the pipeline,
// FIFO and window. If m_tready is low the result is held, the back end stops
// after its next sort, and s_tready drops once FIFO and front end are full.
module calibrated_median_sensor_filter import cmsf_pkg::*; #(
  parameter int WINDOW      = WINDOW_DEF,       // 1..16
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF   // 2 or more
) (
  input  logic                   clk,
  input  logic                   rst,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [S_TDATA_W-1:0]   s_tdata,     // [9:0] raw_code, [15:10] zero
  // output stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [M_TDATA_W-1:0]   m_tdata,     // [31:0] median_value
  // config write port
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]      cfg_data
);

  cfg_t                     cfg;
  logic [CODE_W-1:0]        raw_code;
  logic                     f_valid;
  logic                     f_ready;
  logic signed [DATA_W-1:0] f_data;
  logic                     q_valid;
  logic                     q_ready;
  logic signed [DATA_W-1:0] q_data;
  logic signed [DATA_W-1:0] median_value;

  assign raw_code = s_tdata[CODE_W-1:0];
  assign m_tdata  = median_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain          <= GAIN_RST;
      cfg.offset        <= OFFSET_RST;
      cfg.low_threshold <= LOW_THRESH_RST;
      cfg.high_limit    <= HIGH_LIMIT_RST;
      cfg.range_mode    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN:       cfg.gain          <= cfg_data;
        REG_OFFSET:     cfg.offset        <= cfg_data;
        REG_LOW_THRESH: cfg.low_threshold <= cfg_data;
        REG_HIGH_LIMIT: cfg.high_limit    <= cfg_data;
        REG_RANGE_MODE: cfg.range_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cmsf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .raw_code  (raw_code),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_data  (f_data)
  );

  cmsf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  cmsf_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .in_ready (q_ready),
    .in_data  (q_data),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .m_data   (median_value)
  );

endmodule

### test/cmsf_median_check.sv
`timescale 1ns / 100ps
// Checker for the calibrated median sensor filter: mirrors the calibration,
// the window and its median, follows config writes and compares output items.
// Depends on cmsf_pkg.
module cmsf_median_check import cmsf_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [S_TDATA_W-1:0]   s_tdata,     // [9:0] raw_code, [15:10] zero
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [M_TDATA_W-1:0]   m_tdata,     // [31:0] median_value
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]      cfg_data,
  output int                     errors,
  output int                     outstanding,
  output int                     checked
);

  cfg_t                     cal_cfg;
  logic signed [DATA_W-1:0] window_vals [WINDOW];
  int                       fill;
  logic signed [DATA_W-1:0] medians_due [$];
  int                       err_count;
  int                       check_count;

  function automatic logic signed [DATA_W-1:0] calibrate_code(
    input logic [CODE_W-1:0] code, input cfg_t c);
    longint v;
    v = longint'(code) * longint'($signed(c.gain)) + longint'($signed(c.offset));
    if (v > longint'(SAT_MAX)) v = longint'(SAT_MAX);
    if (v < longint'(SAT_MIN)) v = longint'(SAT_MIN);
    if (v < longint'($signed(c.low_threshold))) v = 0;
    if (c.range_mode && v > longint'($signed(c.high_limit))) v = 0;
    return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] median_of_window();
    int     t [WINDOW];
    int     k;
    int     j;
    longint mid_sum;
    for (int i = 0; i < WINDOW; i++) t[i] = window_vals[i];
    for (int i = 1; i < WINDOW; i++) begin
      k = t[i];
      j = i - 1;
      while (j >= 0 && t[j] > k) begin
        t[j + 1] = t[j];
        j--;
      end
      t[j + 1] = k;
    end
    if (WINDOW % 2 == 1) return t[WINDOW / 2];
    // even window: floored mean of the middle pair
    mid_sum = longint'(t[WINDOW / 2 - 1]) + longint'(t[WINDOW / 2]);
    mid_sum = mid_sum >>> 1;
    return mid_sum[DATA_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic signed [DATA_W-1:0] want;
    if (rst) begin
      cal_cfg = '{gain: GAIN_RST, offset: OFFSET_RST, low_threshold: LOW_THRESH_RST,
                  high_limit: HIGH_LIMIT_RST, range_mode: 1'b0};
      fill = 0;
      medians_due.delete();
      err_count = 0;
      check_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN:       cal_cfg.gain = cfg_data;
          REG_OFFSET:     cal_cfg.offset = cfg_data;
          REG_LOW_THRESH: cal_cfg.low_threshold = cfg_data;
          REG_HIGH_LIMIT: cal_cfg.high_limit = cfg_data;
          REG_RANGE_MODE: cal_cfg.range_mode = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        window_vals[fill] = calibrate_code(s_tdata[CODE_W-1:0], cal_cfg);
        fill++;
        if (fill == WINDOW) begin
          fill = 0;
          medians_due.push_back(median_of_window());
        end
      end
      if (m_tvalid && m_tready) begin
        if (medians_due.size() == 0) begin
          $display("%0t: median item with none expected, expected none, got %0d (0x%08h)",
                   $time, $signed(m_tdata), m_tdata);
          err_count++;
        end else begin
          want = medians_due.pop_front();
          check_count++;
          if (m_tdata !== want) begin
            $display("%0t: median mismatch, expected %0d (0x%08h), got %0d (0x%08h)",
                     $time, want, want, $signed(m_tdata), m_tdata);
            err_count++;
          end
        end
      end
    end
    errors      <= err_count;
    checked     <= check_count;
    outstanding <= medians_due.size();
  end

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// Testbench top for the calibrated median sensor filter: clock, reset, config
// phases, input and output stream pacing, verdict.
// Depends on cmsf_pkg, cmsf_median_check and calibrated_median_sensor_filter.
module tb;
  import cmsf_pkg::*;

  localparam int WINDOW        = WINDOW_DEF;
  localparam int SETTLE_CYCLES = 30;    // front pipe + queue + window shift-in
  localparam int RANDOM_ITEMS  = 1100;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNUSED = REG_RANGE_MODE + 1'b1;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata   = '0;    // [9:0] raw_code, [15:10] zero
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;           // [31:0] median_value
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]      cfg_data  = '0;

  int errors;
  int outstanding;
  int checked;

  bit no_idle    = 1'b0;   // both sides run without gaps while set
  int items_sent = 0;
  int phases     = 1;      // reset defaults count as the first setting

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  calibrated_median_sensor_filter #(.WINDOW(WINDOW)) i_dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_we, .cfg_index, .cfg_data
  );

  cmsf_median_check #(.WINDOW(WINDOW)) i_check (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_we, .cfg_index, .cfg_data,
    .errors, .outstanding, .checked
  );

  // One code per item; random gap first, then hold until accepted.
  task automatic send_code(input logic [CODE_W-1:0] code);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W-CODE_W){1'b0}}, code};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Leaves cfg_we high; the caller drops it after the last write.
  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic write_settings(input cfg_t c);
    put_reg(REG_GAIN, c.gain);
    put_reg(REG_OFFSET, c.offset);
    put_reg(REG_LOW_THRESH, c.low_threshold);
    put_reg(REG_HIGH_LIMIT, c.high_limit);
    put_reg(REG_RANGE_MODE, DATA_W'(c.range_mode));
    // index past the last register: must change nothing
    put_reg(CFG_INDEX_W'($urandom_range(REG_FIRST_UNUSED, 2**CFG_INDEX_W - 1)), $urandom);
    cfg_we <= 1'b0;
    phases++;
  endtask

  // Stop sending, wait for every pending median, then let leftover window
  // items drain from the front pipe and queue so a register write is safe.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly values in a plausible band, sometimes the signed extremes or noise.
  function automatic logic [DATA_W-1:0] pick_word(input int lo, input int hi);
    case ($urandom_range(0, 7))
      0:       return SAT_MIN;
      1:       return SAT_MAX;
      2:       return $urandom;
      default: return lo + int'($urandom_range(0, hi - lo));
    endcase
  endfunction

  function automatic logic [CODE_W-1:0] pick_code();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return CODE_W'($urandom_range(0, 2**CODE_W - 1));
    endcase
  endfunction

  // Output side: random ready gaps per item, no gaps while no_idle is set.
  initial begin : sink
    int gap;
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin : stimulus
    cfg_t cfg;
    int   left;
    int   n;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: floor sits at 20.48 codes, so 20 is zeroed and 21 kept.
    send_code(10'd0);
    send_code(10'd1023);
    send_code(10'd20);
    send_code(10'd21);
    send_code(10'h2AA);
    drain();

    // Largest gain and offset: everything above zero saturates high.
    cfg = '{gain: SAT_MAX, offset: SAT_MAX, low_threshold: SAT_MIN,
            high_limit: SAT_MAX, range_mode: 1'b0};
    write_settings(cfg);
    send_code(10'd1023);
    send_code(10'd1);
    send_code(10'd0);
    send_code(10'h155);
    send_code(10'd0);
    drain();

    // Most negative gain and offset, range mode with the full band: saturates
    // low, code 0 lands exactly on the low bound and is kept.
    cfg = '{gain: SAT_MIN, offset: SAT_MIN, low_threshold: SAT_MIN,
            high_limit: SAT_MAX, range_mode: 1'b1};
    write_settings(cfg);
    send_code(10'd1023);
    send_code(10'd0);
    send_code(10'd512);
    send_code(10'd1);
    send_code(10'h155);
    drain();

    // Unity gain, band 10..20 volts: values on either bound are kept.
    cfg = '{gain: 32'sd65536, offset: 32'sd0, low_threshold: 32'sd655360,
            high_limit: 32'sd1310720, range_mode: 1'b1};
    write_settings(cfg);
    send_code(10'd9);
    send_code(10'd10);
    send_code(10'd20);
    send_code(10'd21);
    send_code(10'd15);
    drain();

    // Empty band (low above high): every value becomes zero.
    cfg = '{gain: 32'sd65536, offset: 32'sd0, low_threshold: 32'sd6553600,
            high_limit: 32'sd0, range_mode: 1'b1};
    write_settings(cfg);
    send_code(10'd0);
    send_code(10'd50);
    send_code(10'd200);
    send_code(10'd1023);
    send_code(10'd100);
    drain();

    // Random phases, each with its own register setting and pacing.
    left = RANDOM_ITEMS;
    while (left > 0) begin
      cfg.gain          = pick_word(-1000, 4000);
      cfg.offset        = pick_word(-(8 << 16), 8 << 16);
      cfg.low_threshold = pick_word(-(2 << 16), 10 << 16);
      cfg.high_limit    = pick_word(0, 40 << 16);
      cfg.range_mode    = 1'($urandom_range(0, 1));
      write_settings(cfg);
      no_idle = ($urandom_range(0, 3) == 0);
      n = $urandom_range(40, 200);
      if (n > left) n = left;
      repeat (n) send_code(pick_code());
      left -= n;
      drain();   // sender holds off until every median is back
    end
    no_idle = 1'b0;

    $display("Run covered %0d codes over %0d register settings, %0d medians compared.",
             items_sent, phases, checked);
    $display("Settings spanned saturating gains, exact and empty bands, with and without gaps.");
    if (errors == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #2ms;
    $display("Timed out with %0d medians still pending.", outstanding);
    $display("== FAIL ==");
    $finish;
  end

endmodule

### sim.f
sv/cmsf_pkg.sv
sv/cmsf_front.sv
sv/cmsf_queue.sv
sv/cmsf_back.sv
sv/calibrated_median_sensor_filter.sv
test/cmsf_median_check.sv
test/tb.sv
